// ===== src/dle_frame_encoder_crc16_defines.svh =====
// ----------------------------------------------------------------------------
// DLE frame encoder assertion macros
// Shared assertion helpers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DLE_FRAME_ENCODER_CRC16_DEFINES_SVH
`define DLE_FRAME_ENCODER_CRC16_DEFINES_SVH

// Same-cycle implication.
`define DFE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dfe: same-cycle check failed");

// Next-cycle implication.
`define DFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dfe: next-cycle check failed");

`endif

// ===== src/dfe_pkg.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder package
// Types, constants and helper functions shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

   // CRC-16/XMODEM generator polynomial.
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Configuration register indexes and reset values.
   localparam logic [1:0] REG_ESCAPE = 2'd0;
   localparam logic [1:0] REG_START  = 2'd1;
   localparam logic [1:0] REG_END    = 2'd2;

   localparam logic [7:0] ESCAPE_RESET = 8'd16;
   localparam logic [7:0] START_RESET  = 8'd2;
   localparam logic [7:0] END_RESET    = 8'd3;

   // One classified input transaction, as handed from front to back.
   typedef struct packed {
      logic        open;      // header must be sent first
      logic        has_byte;  // a payload byte is carried
      logic        close;     // CRC and trailer follow
      logic [7:0]  data;
      logic [15:0] crc;       // CRC to send when closing
   } job_type;

   // Output sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ESC_OPEN,
      PH_START,
      PH_DATA,
      PH_DATA_DUP,
      PH_CRC_HI,
      PH_CRC_HI_DUP,
      PH_CRC_LO,
      PH_CRC_LO_DUP,
      PH_ESC_CLOSE,
      PH_END
   } phase_type;

   // Feeds one byte into a CRC-16/XMODEM register, MSB first.
   function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Phase that follows ph for this job; PH_IDLE means the job is done.
   function automatic phase_type next_phase(job_type job, phase_type ph, logic [7:0] esc);
      phase_type nxt;
      nxt = PH_IDLE;
      case (ph)
         PH_IDLE: begin
            if (job.open) nxt = PH_ESC_OPEN;
            else if (job.has_byte) nxt = PH_DATA;
            else nxt = PH_CRC_HI;
         end
         PH_ESC_OPEN: nxt = PH_START;
         PH_START: nxt = job.has_byte ? PH_DATA : PH_CRC_HI;
         PH_DATA: begin
            if (job.data == esc) nxt = PH_DATA_DUP;
            else nxt = job.close ? PH_CRC_HI : PH_IDLE;
         end
         PH_DATA_DUP: nxt = job.close ? PH_CRC_HI : PH_IDLE;
         PH_CRC_HI: nxt = (job.crc[15:8] == esc) ? PH_CRC_HI_DUP : PH_CRC_LO;
         PH_CRC_HI_DUP: nxt = PH_CRC_LO;
         PH_CRC_LO: nxt = (job.crc[7:0] == esc) ? PH_CRC_LO_DUP : PH_ESC_CLOSE;
         PH_CRC_LO_DUP: nxt = PH_ESC_CLOSE;
         PH_ESC_CLOSE: nxt = PH_END;
         PH_END: nxt = PH_IDLE;
         default: nxt = PH_IDLE;
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ===== src/dfe_req_if.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder request channel
// Valid/ready channel carrying one payload byte with its frame flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;
   logic       empty_frame;

   modport source (output valid, output payload_byte, output last_byte,
                   output empty_frame, input ready);
   modport sink   (input valid, input payload_byte, input last_byte,
                   input empty_frame, output ready);
endinterface

`default_nettype wire

// ===== src/dfe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder response channel
// Valid/ready channel carrying one byte of the framed line stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, output out_byte, output run_last,
                   output frame_end, input ready);
   modport sink   (input valid, input out_byte, input run_last,
                   input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/dle_frame_encoder_crc16.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder with CRC-16/XMODEM trailer
// Frames a payload byte stream with escape/start and escape/end codes,
// stuffs escape bytes and appends the CRC of the unstuffed payload.
//
//   Channel  Direction  Carries
//   req_ch   in         payload_byte, last_byte, empty_frame
//   rsp_ch   out        out_byte, run_last, frame_end
//   csr_*    in/out     escape_code, start_code, end_code (APB)
//
// The back-end sequencer emits one line byte per cycle while the output is
// not stalled; a transaction causes 1 to 10 output bytes.
// The front end accepts a new transaction every cycle while the job queue
// has room, so input and output stall independently.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_frame_encoder_crc16 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   dfe_req_if.sink           req_ch,
   dfe_rsp_if.source         rsp_ch,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [7:0] escape_ff, start_ff, end_ff;
   logic       csr_write;
   logic [1:0] csr_index;

   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_valid;
   dfe_pkg::job_type push_job;
   dfe_pkg::job_type head_job;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= dfe_pkg::ESCAPE_RESET;
         start_ff  <= dfe_pkg::START_RESET;
         end_ff    <= dfe_pkg::END_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dfe_pkg::REG_ESCAPE: escape_ff <= csr_pwdata[7:0];
            dfe_pkg::REG_START:  start_ff  <= csr_pwdata[7:0];
            dfe_pkg::REG_END:    end_ff    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         dfe_pkg::REG_ESCAPE: csr_prdata = {24'h000000, escape_ff};
         dfe_pkg::REG_START:  csr_prdata = {24'h000000, start_ff};
         dfe_pkg::REG_END:    csr_prdata = {24'h000000, end_ff};
         default:             csr_prdata = 32'h00000000;
      endcase
   end

   dfe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   dfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_job  (head_job)
   );

   dfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .escape_code (escape_ff),
      .start_code  (start_ff),
      .end_code    (end_ff),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== src/dfe_front.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder front end
// Accepts request transactions, tracks frame state and CRC, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   dfe_req_if.sink              req,
   input  wire logic            q_full,
   output logic                 q_push,
   output dfe_pkg::job_type     q_job
);

   logic        inside_ff, inside_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // Classify the transaction and advance the running CRC.
   always_comb begin
      crc_base       = inside_ff ? crc_ff : 16'h0000;
      crc_next       = dfe_pkg::crc_feed(crc_base, req.payload_byte);
      q_job.open     = !inside_ff;
      q_job.has_byte = !req.empty_frame;
      q_job.close    = req.empty_frame || req.last_byte;
      q_job.data     = req.payload_byte;
      q_job.crc      = req.empty_frame ? crc_base : crc_next;
      inside_in      = inside_ff;
      crc_in         = crc_ff;
      if (q_push) begin
         inside_in = !q_job.close;
         crc_in    = q_job.close ? 16'h0000 : crc_next;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         crc_ff    <= 16'h0000;
      end else begin
         inside_ff <= inside_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/dfe_queue.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder job queue
// Small FIFO of classified jobs between the front end and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dfe_pkg::job_type  push_job,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output dfe_pkg::job_type       head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfe_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// ===== src/dfe_back.sv =====
// ----------------------------------------------------------------------------
// DLE frame encoder back end
// Sequences each queued job into stuffed line bytes, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dle_frame_encoder_crc16_defines.svh"

module dfe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire dfe_pkg::job_type  q_job,
   output logic                   q_pop,
   input  wire logic [7:0]        escape_code,
   input  wire logic [7:0]        start_code,
   input  wire logic [7:0]        end_code,
   dfe_rsp_if.source              rsp
);

   dfe_pkg::phase_type phase_ff, phase_in;
   dfe_pkg::phase_type cur_phase;
   dfe_pkg::phase_type nxt_phase;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_last_ff, run_last_in;
   logic       frame_end_ff, frame_end_in;
   logic       advance;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.run_last  = run_last_ff;
   assign rsp.frame_end = frame_end_ff;

   assign advance = !rsp_valid_ff || rsp.ready;

   // Current phase, next phase and the byte it emits.
   always_comb begin
      cur_phase = (phase_ff == dfe_pkg::PH_IDLE)
                ? dfe_pkg::next_phase(q_job, dfe_pkg::PH_IDLE, escape_code)
                : phase_ff;
      nxt_phase = dfe_pkg::next_phase(q_job, cur_phase, escape_code);

      byte_in      = byte_ff;
      frame_end_in = 1'b0;
      case (cur_phase)
         dfe_pkg::PH_START:     byte_in = start_code;
         dfe_pkg::PH_DATA:      byte_in = q_job.data;
         dfe_pkg::PH_CRC_HI:    byte_in = q_job.crc[15:8];
         dfe_pkg::PH_CRC_LO:    byte_in = q_job.crc[7:0];
         dfe_pkg::PH_END: begin
            byte_in      = end_code;
            frame_end_in = 1'b1;
         end
         default:               byte_in = escape_code;
      endcase
      run_last_in = (nxt_phase == dfe_pkg::PH_IDLE);

      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      q_pop        = 1'b0;
      if (advance) begin
         rsp_valid_in = q_valid;
         if (q_valid) begin
            phase_in = nxt_phase;
            q_pop    = run_last_in;
         end
      end
   end

   // Sequencer state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dfe_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && q_valid) begin
         byte_ff      <= byte_in;
         run_last_ff  <= run_last_in;
         frame_end_ff <= frame_end_in;
      end
   end

   // A closing code always ends the run of its transaction.
   `DFE_ASSERT_IMP(a_end_is_last, rsp_valid_ff && frame_end_ff, run_last_ff)
   // A job in progress stays at the head of the queue.
   `DFE_ASSERT_IMP(a_phase_has_job, phase_ff != dfe_pkg::PH_IDLE, q_valid)
   // Finishing a job returns the sequencer to its start.
   `DFE_ASSERT_NEXT(a_pop_to_idle, q_pop, phase_ff == dfe_pkg::PH_IDLE)

endmodule

`default_nettype wire
